// ===== sv/pca_pkg.sv =====
package pca_pkg;

	localparam int COORD_W      = 16;
	localparam int MAX_VERTICES = 1024; // sum widths below are exact up to this many vertices
	localparam int AREA_W       = 44;
	localparam int MOMENT_W     = 61;
	localparam int DEN_W        = AREA_W + 2;
	localparam int QUO_W        = MOMENT_W;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic signed [COORD_W-1:0] vertex_z;
		logic                      last_vertex;
	} in_word_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] centroid_x;
		logic signed [COORD_W-1:0] centroid_y;
		logic signed [COORD_W-1:0] centroid_z;
		logic                      zero_area;
	} out_word_t;

	// one edge from the front part to the back part
	typedef struct packed {
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] fz;
		logic                      clr;  // first edge of a polygon: start sums fresh
		logic                      skip; // first vertex: no edge, only clear
		logic                      fin;  // closing edge: produce a result
	} edge_t;

endpackage

// ===== sv/pca_front.sv =====
module pca_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  pca_pkg::in_word_t  word,
	output logic               e_valid,
	input  logic               e_stall,
	output pca_pkg::edge_t     e_word
);
	// A last vertex emits two edges: previous->current, then current->first.
	logic                              in_poly_q;
	logic signed [pca_pkg::COORD_W-1:0] fx_q, fy_q, fz_q, prx_q, pry_q;
	logic                              close_q;
	logic                              acc;

	assign stall = close_q || (e_valid && e_stall);
	assign acc   = valid && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_poly_q <= 1'b0;
			close_q   <= 1'b0;
			e_valid   <= 1'b0;
			fx_q <= '0; fy_q <= '0; fz_q <= '0; prx_q <= '0; pry_q <= '0;
		end else begin
			if (e_valid && !e_stall)
				e_valid <= 1'b0;
			if (close_q && !(e_valid && e_stall)) begin
				e_valid       <= 1'b1;
				e_word.px     <= prx_q;
				e_word.py     <= pry_q;
				e_word.cx     <= fx_q;
				e_word.cy     <= fy_q;
				e_word.fz     <= fz_q;
				e_word.clr    <= 1'b0;
				e_word.skip   <= 1'b0;
				e_word.fin    <= 1'b1;
				close_q       <= 1'b0;
				in_poly_q     <= 1'b0;
			end else if (acc) begin
				e_valid     <= 1'b1;
				e_word.px   <= prx_q;
				e_word.py   <= pry_q;
				e_word.cx   <= word.vertex_x;
				e_word.cy   <= word.vertex_y;
				e_word.fz   <= fz_q;
				e_word.clr  <= !in_poly_q;
				e_word.skip <= !in_poly_q;
				e_word.fin  <= 1'b0;
				if (!in_poly_q) begin
					fx_q <= word.vertex_x;
					fy_q <= word.vertex_y;
					fz_q <= word.vertex_z;
					e_word.fz <= word.vertex_z;
				end
				prx_q     <= word.vertex_x;
				pry_q     <= word.vertex_y;
				in_poly_q <= 1'b1;
				close_q   <= word.last_vertex;
			end
		end
	end
endmodule

// ===== sv/pca_div.sv =====
module pca_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [pca_pkg::MOMENT_W-1:0] num,
	input  logic signed [pca_pkg::DEN_W-1:0]    den,
	output logic                                busy,
	output logic                                done,
	output logic signed [pca_pkg::COORD_W-1:0]  quo
);
	// restoring divide on magnitudes, one bit per cycle, truncating, then saturated to COORD_W
	localparam int N     = pca_pkg::MOMENT_W;
	localparam int CNT_W = $clog2(N + 1);
	localparam logic signed [N-1:0] HI = N'((1 << (pca_pkg::COORD_W - 1)) - 1);
	localparam logic signed [N-1:0] LO = -HI - N'(1);
	logic [N-1:0]                 q_q;
	logic [pca_pkg::DEN_W:0]      r_q;
	logic [pca_pkg::DEN_W-1:0]    d_q;
	logic                         neg_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [pca_pkg::DEN_W:0]      r_sh;
	logic [N-1:0]                 qs;

	assign r_sh = {r_q[pca_pkg::DEN_W-1:0], q_q[N-1]};
	assign qs   = neg_q ? -q_q : q_q;

	always_comb begin
		if (!neg_q && q_q > N'(HI))
			quo = HI[pca_pkg::COORD_W-1:0];
		else if (neg_q && q_q > N'(-LO))
			quo = LO[pca_pkg::COORD_W-1:0];
		else
			quo = qs[pca_pkg::COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
			neg_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				cnt_q <= CNT_W'(N);
				neg_q <= num[N-1] ^ den[pca_pkg::DEN_W-1];
				q_q   <= num[N-1] ? -num : num;
				d_q   <= den[pca_pkg::DEN_W-1] ? -den : den;
				r_q   <= '0;
			end else if (busy) begin
				if (r_sh >= {1'b0, d_q}) begin
					r_q <= r_sh - {1'b0, d_q};
					q_q <= {q_q[N-2:0], 1'b1};
				end else begin
					r_q <= r_sh;
					q_q <= {q_q[N-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== sv/pca_back.sv =====
module pca_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                e_valid,
	output logic                e_stall,
	input  pca_pkg::edge_t      e_word,
	output logic                valid,
	input  logic                stall,
	output pca_pkg::out_word_t  word
);
	typedef enum logic [2:0] {S_IDLE, S_MUL, S_ACC, S_CHK, S_DIVX, S_DIVY, S_OUT} st_t;
	localparam int CW = pca_pkg::COORD_W;
	st_t st_q;
	pca_pkg::edge_t ed_q;
	logic signed [2*CW-1:0]                a_s1, b_s1;
	logic signed [2*CW:0]                  cr_s2;
	logic signed [CW:0]                    sx_s2, sy_s2;
	logic signed [pca_pkg::AREA_W-1:0]     area_q;
	logic signed [pca_pkg::MOMENT_W-1:0]   mx_q, my_q;
	logic signed [pca_pkg::DEN_W-1:0]      den;
	logic                                  dstart, dbusy, ddone;
	logic signed [CW-1:0]                  dquo, cx_q;
	logic signed [pca_pkg::MOMENT_W-1:0]   dnum;
	logic signed [3*CW+1:0]                pmx, pmy;
	logic signed [pca_pkg::MOMENT_W-1:0]   tx, ty;

	assign den     = 3 * pca_pkg::DEN_W'(area_q);
	assign e_stall = (st_q != S_IDLE);
	// 33 x 17 bit products, exact before widening to the moment width
	assign pmx = cr_s2 * sx_s2;
	assign pmy = cr_s2 * sy_s2;
	assign tx  = pca_pkg::MOMENT_W'(pmx);
	assign ty  = pca_pkg::MOMENT_W'(pmy);
	assign dnum = (st_q == S_DIVX) ? mx_q : my_q;

	pca_div u_div (.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(den),
		.busy(dbusy), .done(ddone), .quo(dquo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			valid  <= 1'b0;
			dstart <= 1'b0;
			area_q <= '0; mx_q <= '0; my_q <= '0;
		end else begin
			dstart <= 1'b0;
			unique case (st_q)
				S_IDLE: if (e_valid) begin
					ed_q <= e_word;
					a_s1 <= e_word.cx * e_word.py;
					b_s1 <= e_word.cy * e_word.px;
					sx_s2 <= (CW+1)'(e_word.cx) + (CW+1)'(e_word.px);
					sy_s2 <= (CW+1)'(e_word.cy) + (CW+1)'(e_word.py);
					st_q <= S_MUL;
				end
				S_MUL: begin
					cr_s2 <= (2*CW+1)'(a_s1) - (2*CW+1)'(b_s1);
					st_q  <= S_ACC;
				end
				S_ACC: begin
					// accumulate edge, or clear the sums on a skip edge (first vertex)
					if (ed_q.skip) begin
						area_q <= '0; mx_q <= '0; my_q <= '0;
						st_q <= S_IDLE;
					end else begin
						area_q <= area_q + pca_pkg::AREA_W'(cr_s2);
						mx_q <= mx_q + tx;
						my_q <= my_q + ty;
						if (ed_q.fin)
							st_q <= S_CHK;
						else
							st_q <= S_IDLE;
					end
				end
				// divider only runs for a nonzero area, so no stale done can arrive
				S_CHK: if (area_q == '0) begin
					word <= '{'0, '0, ed_q.fz, 1'b1};
					valid <= 1'b1;
					st_q <= S_OUT;
				end else begin
					dstart <= 1'b1;
					st_q <= S_DIVX;
				end
				S_DIVX: if (ddone) begin
					cx_q <= dquo;
					dstart <= 1'b1;
					st_q <= S_DIVY;
				end
				S_DIVY: if (ddone) begin
					word <= '{cx_q, dquo, ed_q.fz, 1'b0};
					valid <= 1'b1;
					st_q <= S_OUT;
				end
				S_OUT: if (!stall) begin
					valid <= 1'b0;
					area_q <= '0; mx_q <= '0; my_q <= '0;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && stall |=> valid) else $error("result dropped");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> e_stall) else $error("edge taken while result pending");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> !dbusy) else $error("divider busy in idle");
endmodule

// ===== sv/polygon_centroid_accumulator_top.sv =====
// Polygon centroid by shoelace sums, signed Q12.4.
// Input channel in_valid/in_stall/in_word carries one vertex per word;
// last_vertex closes the polygon back to its first vertex.
// Output channel out_valid/out_stall/out_word carries one centroid per
// polygon: moment / (3 * twice area), truncated, saturated to 16 bits,
// with the first vertex's z. Zero area gives x = y = 0 and zero_area = 1.
// A front part turns vertices into edges; a one-edge register separates it
// from the back part, which forms the cross and moment products and
// accumulates them in S_IDLE, S_MUL and S_ACC, taking an edge only in S_IDLE.
// The closing vertex adds a closing edge, a zero-area check and two serial
// 61-step divides through one shared divider; when the area is zero no
// divide runs.
// Reset clears the control state and the sums; the next vertex starts a new polygon.
// While out_stall is high the result holds and the back part waits;
// the front still takes one more vertex into its edge register.
module polygon_centroid_accumulator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pca_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output pca_pkg::out_word_t out_word
);
	logic           e_valid, e_stall;
	pca_pkg::edge_t e_word;

	pca_front u_front (.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall),
		.word(in_word), .e_valid(e_valid), .e_stall(e_stall), .e_word(e_word));

	pca_back u_back (.clk(clk), .arst_n(arst_n), .e_valid(e_valid), .e_stall(e_stall),
		.e_word(e_word), .valid(out_valid), .stall(out_stall), .word(out_word));
endmodule
